>>> src/anbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbs_pkg
// Types and constants shared by the Annex B NAL unit splitter modules.
// ----------------------------------------------------------------------------
package anbs_pkg;

	localparam int MAX_RES   = 4;
	localparam int RES_CNT_W = 3;
	localparam int RES_IDX_W = 2;
	localparam int WIN_DEPTH = 3;
	localparam int WIN_CNT_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [4:0] TYPE_MASK         = 5'h1f;
	localparam logic [4:0] DEFAULT_DROP_TYPE = 5'h09;

	localparam logic [CFG_IDX_W-1:0] REG_DROP_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_TYPE   = 2'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} item_t;

	typedef struct packed {
		logic [7:0] nal_byte;
		logic       first_of_nal;
		logic       last_of_nal;
		logic [4:0] nal_type;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [MAX_RES-1:0]      last;
		logic                    first;
		logic [4:0]              nal_type;
		logic [RES_CNT_W-1:0]    count;
	} batch_t;

endpackage

>>> src/annexb_nal_unit_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an Annex B byte stream into NAL unit payload bytes with framing marks.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle while item_ready is high and returns
// NAL unit payload bytes without start codes through the item_s1 register and
// the result register. Up to three payload bytes are held back so that the
// byte before the next start code can be marked last; a byte can thus release
// zero to four results, handed out one per cycle while result_ready is high.
// Items are accepted every cycle while each releases at most one result that is
// taken at once; else the input is held until the last result is taken. Units
// whose type equals drop_type are removed whole while drop_enable is set, and
// the registers may only be written while the block is idle.
module annexb_nal_unit_splitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  anbs_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output anbs_pkg::result_t               result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [anbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [anbs_pkg::CFG_DATA_W-1:0] cfg_data
);

	anbs_pkg::item_t  item_s1;
	logic             valid_s1;
	logic             load_ready;
	logic             take;
	anbs_pkg::batch_t batch;

	assign take       = valid_s1 && load_ready;
	assign item_ready = !valid_s1 || take;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	anbs_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (take),
		.item      (item_s1),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.batch     (batch)
	);

	anbs_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (valid_s1),
		.load_batch   (batch),
		.load_ready   (load_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

>>> src/anbs_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbs_framer
// Start code search, byte window and drop control; turns one item into a
// batch of up to four payload bytes and holds the configuration registers.
// ----------------------------------------------------------------------------
module anbs_framer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  anbs_pkg::item_t                 item,
	input  logic                            cfg_valid,
	input  logic [anbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [anbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output anbs_pkg::batch_t                batch
);

	logic [anbs_pkg::WIN_DEPTH-1:0][7:0] win_q, win_n;
	logic [anbs_pkg::WIN_CNT_W-1:0]      cnt_q, cnt_n;
	logic                                inside_q, inside_n;
	logic                                expect_q, expect_n;
	logic [4:0]                          type_q, type_n;
	logic                                drop_q, drop_n;
	logic                                drop_enable_q;
	logic [4:0]                          drop_type_q;

	logic [anbs_pkg::MAX_RES-1:0][7:0]   cand_byte;
	logic [anbs_pkg::MAX_RES-1:0]        cand_last;
	logic [anbs_pkg::RES_CNT_W-1:0]      ncand;
	logic                                drop_put;
	logic                                z2;
	logic [7:0]                          b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_enable_q <= 1'b1;
			drop_type_q   <= anbs_pkg::DEFAULT_DROP_TYPE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				anbs_pkg::REG_DROP_ENABLE: drop_enable_q <= cfg_data[0];
				anbs_pkg::REG_DROP_TYPE:   drop_type_q   <= cfg_data & anbs_pkg::TYPE_MASK;
				default: ;
			endcase
		end
	end

	always_comb begin
		b        = item.data_byte;
		win_n    = win_q;
		cnt_n    = cnt_q;
		inside_n = inside_q;
		expect_n = expect_q;
		type_n   = type_q;
		drop_n   = drop_q;
		cand_byte = '0;
		cand_last = '0;
		ncand    = '0;
		drop_put = drop_q;
		z2 = (cnt_q >= 2'd2) && (win_q[cnt_q - 2'd2] == 8'h00) &&
			(win_q[cnt_q - 2'd1] == 8'h00);

		if (inside_q) begin
			if (z2 && (b == 8'h00 || b == 8'h01)) begin
				if (cnt_q == 2'd3) begin
					cand_byte[0] = win_q[0];
					cand_last[0] = 1'b1;
					ncand        = 3'd1;
				end
				win_n  = '0;
				drop_n = 1'b0;
				if (b == 8'h01) begin
					cnt_n    = 2'd0;
					expect_n = 1'b1;
				end else begin
					inside_n = 1'b0;
					expect_n = 1'b0;
					cnt_n    = 2'd2;
				end
			end else if (cnt_q == 2'd3) begin
				cand_byte[0] = win_q[0];
				ncand        = 3'd1;
				expect_n     = 1'b0;
				win_n        = {b, win_q[2], win_q[1]};
				if (item.end_of_stream) begin
					cand_byte[1] = win_q[1];
					cand_byte[2] = win_q[2];
					cand_byte[3] = b;
					cand_last[3] = 1'b1;
					ncand        = 3'd4;
				end
			end else begin
				if (cnt_q == 2'd0) begin
					type_n = b[4:0] & anbs_pkg::TYPE_MASK;
					drop_n = drop_enable_q && (type_n == drop_type_q);
				end
				win_n[cnt_q] = b;
				cnt_n        = cnt_q + 2'd1;
				drop_put     = drop_n;
				if (item.end_of_stream) begin
					for (int i = 0; i < anbs_pkg::MAX_RES; i++) begin
						if (i < int'(cnt_q)) begin
							cand_byte[i] = win_q[i];
						end else if (i == int'(cnt_q)) begin
							cand_byte[i] = b;
							cand_last[i] = 1'b1;
						end
					end
					ncand = {1'b0, cnt_q} + 3'd1;
				end
			end
		end else begin
			win_n = '0;
			if (z2 && b == 8'h01) begin
				cnt_n    = 2'd0;
				inside_n = 1'b1;
				expect_n = 1'b1;
				drop_n   = 1'b0;
			end else if (cnt_q != 2'd0) begin
				win_n[0] = win_q[cnt_q - 2'd1];
				win_n[1] = b;
				cnt_n    = 2'd2;
			end else begin
				win_n[0] = b;
				cnt_n    = 2'd1;
			end
		end

		if (item.end_of_stream) begin
			win_n    = '0;
			cnt_n    = 2'd0;
			inside_n = 1'b0;
			expect_n = 1'b0;
			drop_n   = 1'b0;
		end

		batch.bytes    = cand_byte;
		batch.last     = cand_last;
		batch.first    = expect_q;
		batch.nal_type = type_n;
		batch.count    = drop_put ? '0 : ncand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			cnt_q    <= '0;
			inside_q <= 1'b0;
			expect_q <= 1'b0;
			type_q   <= '0;
			drop_q   <= 1'b0;
		end else if (go) begin
			win_q    <= win_n;
			cnt_q    <= cnt_n;
			inside_q <= inside_n;
			expect_q <= expect_n;
			type_q   <= type_n;
			drop_q   <= drop_n;
		end
	end

endmodule

>>> src/anbs_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbs_out_buf
// Result register that holds one batch and hands its bytes out one per handshake.
// ----------------------------------------------------------------------------
module anbs_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  anbs_pkg::batch_t    load_batch,
	output logic                load_ready,
	output logic                result_valid,
	input  logic                result_ready,
	output anbs_pkg::result_t   result
);

	anbs_pkg::batch_t                 batch_s2;
	logic [anbs_pkg::RES_CNT_W-1:0]   cnt_s2;
	logic [anbs_pkg::RES_IDX_W-1:0]   idx_q;
	logic                             pop;
	logic                             last_pop;
	logic                             at_end;

	assign result_valid = (cnt_s2 != '0);
	assign pop          = result_valid && result_ready;
	assign at_end       = ({1'b0, idx_q} == cnt_s2 - 3'd1);
	assign last_pop     = pop && at_end;
	assign load_ready   = (cnt_s2 == '0) || last_pop;

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			batch_s2 <= load_batch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
			idx_q  <= '0;
		end else if (load_valid && load_ready) begin
			cnt_s2 <= load_batch.count;
			idx_q  <= '0;
		end else if (last_pop) begin
			cnt_s2 <= '0;
			idx_q  <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_comb begin
		result.nal_byte     = batch_s2.bytes[idx_q];
		result.first_of_nal = batch_s2.first && (idx_q == '0);
		result.last_of_nal  = batch_s2.last[idx_q];
		result.nal_type     = batch_s2.nal_type;
		result.last_of_run  = at_end;
	end

endmodule

>>> verif/nal_split_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_split_checker
// Watches the stream, result and register channels of the NAL unit splitter.
// It keeps its own copy of the start code search, the held-back payload bytes
// and the drop registers. For every stream byte taken in it queues the NAL
// bytes that the byte releases, and it compares each returned result with the
// oldest queued one.
// ----------------------------------------------------------------------------
module nal_split_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_ready,
	input  anbs_pkg::item_t                 item,
	input  logic                            result_valid,
	input  logic                            result_ready,
	input  anbs_pkg::result_t               result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [anbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [anbs_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              queued
);

	localparam int PRINT_LIMIT = 100;

	logic [7:0]        win [0:anbs_pkg::WIN_DEPTH-1];
	int                win_cnt;
	bit                in_unit;
	bit                hdr_pending;
	bit                discarding;
	logic [4:0]        cur_type;
	bit                drop_en;
	logic [4:0]        drop_type;
	anbs_pkg::result_t step_q[$];
	anbs_pkg::result_t nal_expected[$];

	task automatic report(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void clear_window();
		for (int i = 0; i < anbs_pkg::WIN_DEPTH; i++)
			win[i] = 8'h00;
	endfunction

	function automatic void clear_framing();
		clear_window();
		win_cnt = 0;
		in_unit = 1'b0;
		hdr_pending = 1'b0;
		discarding = 1'b0;
	endfunction

	function automatic void emit_byte(input logic [7:0] v, input bit last_b);
		anbs_pkg::result_t r;
		bit                first_b;
		first_b = hdr_pending;
		hdr_pending = 1'b0;
		if (discarding || step_q.size() >= anbs_pkg::MAX_RES)
			return;
		r.nal_byte = v;
		r.first_of_nal = first_b;
		r.last_of_nal = last_b;
		r.nal_type = cur_type & anbs_pkg::TYPE_MASK;
		r.last_of_run = 1'b0;
		step_q.push_back(r);
	endfunction

	function automatic void split_byte(input logic [7:0] b, input bit eos);
		logic [7:0] seq [0:3];
		int         n;
		int         len;
		step_q.delete();
		n = (win_cnt > anbs_pkg::WIN_DEPTH) ? anbs_pkg::WIN_DEPTH : win_cnt;
		for (int i = 0; i < n; i++)
			seq[i] = win[i];
		seq[n] = b;
		len = n + 1;
		if (in_unit) begin
			if (len >= 3 && seq[len-3] == 8'h00 && seq[len-2] == 8'h00 &&
			    (seq[len-1] == 8'h00 || seq[len-1] == 8'h01)) begin
				for (int i = 0; i < len - 3; i++)
					emit_byte(seq[i], i == len - 4);
				clear_window();
				discarding = 1'b0;
				if (seq[len-1] == 8'h01) begin
					win_cnt = 0;
					hdr_pending = 1'b1;
				end else begin
					in_unit = 1'b0;
					hdr_pending = 1'b0;
					win_cnt = 2;
				end
			end else if (n == anbs_pkg::WIN_DEPTH) begin
				emit_byte(seq[0], 1'b0);
				win[0] = seq[1];
				win[1] = seq[2];
				win[2] = seq[3];
				win_cnt = anbs_pkg::WIN_DEPTH;
			end else begin
				if (n == 0) begin
					cur_type = b[4:0] & anbs_pkg::TYPE_MASK;
					discarding = drop_en && cur_type == drop_type;
				end
				win[n] = b;
				win_cnt = n + 1;
			end
		end else begin
			clear_window();
			if (len >= 3 && seq[len-3] == 8'h00 && seq[len-2] == 8'h00 &&
			    seq[len-1] == 8'h01) begin
				win_cnt = 0;
				in_unit = 1'b1;
				hdr_pending = 1'b1;
				discarding = 1'b0;
			end else if (len >= 2) begin
				win[0] = seq[len-2];
				win[1] = seq[len-1];
				win_cnt = 2;
			end else begin
				win[0] = seq[0];
				win_cnt = 1;
			end
		end
		if (eos) begin
			if (in_unit) begin
				n = (win_cnt > anbs_pkg::WIN_DEPTH) ? anbs_pkg::WIN_DEPTH : win_cnt;
				for (int i = 0; i < n; i++)
					emit_byte(win[i], i == n - 1);
			end
			clear_framing();
		end
		if (step_q.size() > 0)
			step_q[step_q.size()-1].last_of_run = 1'b1;
		foreach (step_q[i])
			nal_expected.push_back(step_q[i]);
	endfunction

	task automatic check_result(input anbs_pkg::result_t got);
		anbs_pkg::result_t want;
		if (nal_expected.size() == 0) begin
			report($sformatf("result %h arrived with no NAL byte pending", got));
			return;
		end
		want = nal_expected.pop_front();
		if (got.nal_byte !== want.nal_byte)
			report($sformatf("nal_byte %h, expected %h", got.nal_byte, want.nal_byte));
		if (got.first_of_nal !== want.first_of_nal)
			report($sformatf("first_of_nal %b, expected %b", got.first_of_nal,
				want.first_of_nal));
		if (got.last_of_nal !== want.last_of_nal)
			report($sformatf("last_of_nal %b, expected %b", got.last_of_nal,
				want.last_of_nal));
		if (got.nal_type !== want.nal_type)
			report($sformatf("nal_type %0d, expected %0d", got.nal_type, want.nal_type));
		if (got.last_of_run !== want.last_of_run)
			report($sformatf("last_of_run %b, expected %b", got.last_of_run,
				want.last_of_run));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_framing();
			cur_type = 5'd0;
			drop_en = 1'b1;
			drop_type = anbs_pkg::DEFAULT_DROP_TYPE;
			nal_expected.delete();
			queued <= 0;
		end else begin
			if (result_valid && result_ready)
				check_result(result);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == anbs_pkg::REG_DROP_ENABLE)
					drop_en = cfg_data[0];
				else if (cfg_index == anbs_pkg::REG_DROP_TYPE)
					drop_type = cfg_data & anbs_pkg::TYPE_MASK;
			end
			if (item_valid && item_ready)
				split_byte(item.data_byte, item.end_of_stream);
			queued <= nal_expected.size();
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream stimulus for the Annex B NAL unit splitter.
// A short directed stream covers garbage before the first start code, both
// start code lengths, a dropped delimiter unit, an emulation prevention
// pattern, an empty unit, a unit closed by three zeros and end of stream.
// Random phases then send framed units with random content and noise under
// several drop settings, with sender gaps, receiver stalls and one long
// receiver hold-off. A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb;

	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 16;
	localparam int PHASE_ITEMS   = 36;
	localparam int OPENING_LEN   = 26;

	localparam logic [anbs_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [anbs_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam logic [0:OPENING_LEN-1][7:0] OPENING = {
		8'hFF, 8'h00, 8'h00, 8'h01, 8'h09, 8'hF0,
		8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h03,
		8'h00, 8'h00, 8'h01,
		8'h00, 8'h00, 8'h01,
		8'h80, 8'h00, 8'h00, 8'h00,
		8'h01, 8'h7F
	};

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            item_valid = 1'b0;
	logic                            item_ready;
	anbs_pkg::item_t                 item = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	anbs_pkg::result_t               result;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [anbs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [anbs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int              mismatches;
	int              queued;
	int              send_idle_pct = 0;
	int              stall_pct = 0;
	bit              hold_req = 1'b0;
	bit              hold_done = 1'b0;
	int              hold_left = 0;
	int              quiet = 0;
	logic [4:0]      pick;
	anbs_pkg::item_t stream_q[$];

	annexb_nal_unit_splitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	nal_split_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.queued       (queued)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic void push_byte(input logic [7:0] b, input bit eos);
		anbs_pkg::item_t it;
		it.data_byte = b;
		it.end_of_stream = eos;
		stream_q.push_back(it);
	endfunction

	// Zeros, 03 and 01 come often so that start code look-alikes and
	// emulation prevention patterns turn up inside payloads.
	function automatic logic [7:0] payload_byte();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 8'h00;
		else if (r < 35)
			return 8'h03;
		else if (r < 40)
			return 8'h01;
		return 8'($urandom_range(255));
	endfunction

	function automatic void add_unit(input logic [4:0] hot_type);
		logic [4:0] kind;
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 3)) push_byte(payload_byte(), 1'b0);
		repeat ($urandom_range(0, 2)) push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0);
		if ($urandom_range(99) < 6)
			return;
		kind = $urandom_range(1) ? hot_type : 5'($urandom_range(31));
		push_byte({3'($urandom_range(7)), kind}, 1'b0);
		repeat ($urandom_range(0, 6)) push_byte(payload_byte(), 1'b0);
		if ($urandom_range(99) < 10)
			stream_q[stream_q.size()-1].end_of_stream = 1'b1;
	endfunction

	task automatic send_item(input anbs_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic send_stream();
		foreach (stream_q[i])
			send_item(stream_q[i]);
		stream_q.delete();
		item_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [anbs_pkg::CFG_IDX_W-1:0] idx,
		input logic [anbs_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic settle(input int extra);
		do @(posedge clk); while (queued != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic random_phase(input int idle, input int stall, input logic [4:0] hot_type);
		send_idle_pct = idle;
		stall_pct = stall;
		while (stream_q.size() < PHASE_ITEMS)
			add_unit(hot_type);
		send_stream();
		settle(SETTLE_CYCLES);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < OPENING_LEN; i++)
			push_byte(OPENING[i], i == OPENING_LEN - 1);
		send_stream();
		settle(SETTLE_CYCLES);

		write_reg(anbs_pkg::REG_DROP_ENABLE, {4'($urandom_range(15)), 1'b0});
		write_reg(anbs_pkg::REG_DROP_TYPE, 5'h1F);
		cfg_valid <= 1'b0;
		random_phase(87, 0, 5'h1F);

		write_reg(anbs_pkg::REG_DROP_ENABLE, 5'h01);
		write_reg(anbs_pkg::REG_DROP_TYPE, 5'h00);
		write_reg(REG_SPARE_A, 5'($urandom_range(31)));
		cfg_valid <= 1'b0;
		hold_req = 1'b1;
		random_phase(0, 87, 5'h00);

		pick = 5'($urandom_range(31));
		write_reg(REG_SPARE_B, 5'($urandom_range(31)));
		write_reg(anbs_pkg::REG_DROP_TYPE, pick);
		write_reg(anbs_pkg::REG_DROP_ENABLE, 5'h1F);
		cfg_valid <= 1'b0;
		random_phase(37, 37, pick);

		write_reg(anbs_pkg::REG_DROP_TYPE, anbs_pkg::DEFAULT_DROP_TYPE);
		write_reg(anbs_pkg::REG_DROP_ENABLE, 5'h03);
		cfg_valid <= 1'b0;
		random_phase(0, 0, anbs_pkg::DEFAULT_DROP_TYPE);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && queued == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
